// ===== sv/pictl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pictl_pkg: shared types and constants of the saturating PI controller
// Word widths, register indexes and the saturate-and-clamp function that the
// integrator and output paths both use.
// ----------------------------------------------------------------------------
package pictl_pkg;

  localparam int DATA_W    = 16;  // setpoint, measurement, limits, gains
  localparam int SHIFT_W   = 6;   // signed shift settings
  localparam int ERR_W     = DATA_W + 1;
  localparam int PROD_W    = ERR_W + DATA_W;  // error times gain
  localparam int ACC_W     = 32;  // integrator and output sum
  localparam int LIMIT_POS = 16;  // limits sit in the upper half of the sum
  localparam int IDX_W     = 3;   // register index bits of the address
  localparam int ADDR_W    = IDX_W + 2;

  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [ACC_W+1:0]   wide_t;

  localparam acc_t ACC_MAX = 32'sh7FFF_FFFF;
  localparam acc_t ACC_MIN = -32'sh7FFF_FFFF - 32'sh1;

  // Register indexes, as seen on address bits [4:2].
  localparam logic [IDX_W-1:0] REG_PGAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IGAIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PSHIFT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ISHIFT = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOWER  = 3'd4;

  // Saturates a widened sum to 32 bits, then clamps it to [lo, hi]. The lower
  // clamp comes last so it wins when the limits cross.
  function automatic acc_t sat_clamp(input wide_t v, input acc_t hi, input acc_t lo);
    acc_t r;
    if (v[ACC_W+1:ACC_W-1] == 3'b000 || v[ACC_W+1:ACC_W-1] == 3'b111) begin
      r = v[ACC_W-1:0];
    end else if (v[ACC_W+1]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pictl_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pictl_scale: product scaling by a signed shift
// A non-negative shift is a flooring arithmetic right shift; a negative shift
// clamps the product to what survives the shift and then shifts it left.
// ----------------------------------------------------------------------------
module pictl_scale (
  input  wire pictl_pkg::prod_t  prod_i,
  input  wire pictl_pkg::shift_t shift_i,
  output pictl_pkg::prod_t       term_o
);
  import pictl_pkg::*;

  logic [SHIFT_W-1:0] neg_sh;
  logic [4:0]         n;
  prod_t              lim;
  prod_t              clamped;

  // A shift of minus thirty-two acts as minus thirty-one.
  assign neg_sh = SHIFT_W'(-shift_i);
  assign n      = neg_sh[SHIFT_W-1] ? 5'd31 : neg_sh[4:0];
  assign lim    = PROD_W'(32'h7FFF_FFFF >> n);

  always_comb begin
    if (prod_i > lim) begin
      clamped = lim;
    end else if (prod_i < -lim) begin
      clamped = -lim;
    end else begin
      clamped = prod_i;
    end
    if (shift_i[SHIFT_W-1]) begin
      term_o = clamped <<< n;
    end else begin
      term_o = prod_i >>> shift_i[4:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/pi_controller_saturating_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pi_controller_saturating_top: fixed-point PI regulator with anti-windup
// Error times two gains, shift scaling, saturating integrator and output,
// both clamped to a lower limit register and an upper limit per word.
// ----------------------------------------------------------------------------
// The regulator takes one word per clock while in_stall is low and returns
// one result word for every input word, in order. A word passes three
// registers: the input register, the product register after the two 17x16
// gain multipliers, and the result register. out_valid rises as the word
// enters the result register. The integrator is updated when a word moves
// from the product register into the result register, so the integrator
// loop closes through the integrator register alone and words may follow
// each other back to back. Each stage keeps its word while the stage after
// it is full and stalled, so a held result on the output does not stop the
// upstream stages from filling. Gains, shifts and the lower limit are
// written through the APB port; the user must write them only while the
// block is idle, as the block itself does not enforce it. Registers read
// back sign-extended to 32 bits. A word with clear_integral set still
// produces its output from the stepped integrator and then zeroes it.
// ----------------------------------------------------------------------------
module pi_controller_saturating_top (
  input  wire                           clk,
  input  wire                           rst_n,
  // Input channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire pictl_pkg::data_t         in_setpoint,
  input  wire pictl_pkg::data_t         in_measured,
  input  wire pictl_pkg::data_t         in_upper_limit,
  input  wire                           in_clear_integral,
  // Result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output pictl_pkg::data_t              out_control_value,
  // Configuration port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [pictl_pkg::ADDR_W-1:0]   paddr,
  input  wire [31:0]                    pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pictl_pkg::*;

  // Configuration registers.
  data_t  pgain_r;
  data_t  igain_r;
  shift_t pshift_r;
  shift_t ishift_r;
  data_t  lower_r;

  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pgain_r  <= '0;
      igain_r  <= '0;
      pshift_r <= '0;
      ishift_r <= '0;
      lower_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PGAIN:  pgain_r  <= pwdata[DATA_W-1:0];
        REG_IGAIN:  igain_r  <= pwdata[DATA_W-1:0];
        REG_PSHIFT: pshift_r <= pwdata[SHIFT_W-1:0];
        REG_ISHIFT: ishift_r <= pwdata[SHIFT_W-1:0];
        REG_LOWER:  lower_r  <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PGAIN:  prdata = 32'(pgain_r);
      REG_IGAIN:  prdata = 32'(igain_r);
      REG_PSHIFT: prdata = 32'(pshift_r);
      REG_ISHIFT: prdata = 32'(ishift_r);
      REG_LOWER:  prdata = 32'(lower_r);
      default:    prdata = '0;
    endcase
  end

  // Pipeline flow control. Each stage moves on when the next one is empty or
  // moving on itself in the same cycle.
  logic  s1_valid_r, s2_valid_r, out_valid_r;
  logic  s2_go, s1_go, in_take;

  assign s2_go    = s2_valid_r & (~out_valid_r | ~out_stall);
  assign s1_go    = s1_valid_r & (~s2_valid_r | s2_go);
  assign in_stall = s1_valid_r & s2_valid_r & ~s2_go;
  assign in_take  = in_valid & ~in_stall;

  // Stage 1: input register.
  data_t s1_setpoint_r, s1_measured_r, s1_upper_r;
  logic  s1_clr_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_setpoint_r <= in_setpoint;
      s1_measured_r <= in_measured;
      s1_upper_r    <= in_upper_limit;
      s1_clr_r      <= in_clear_integral;
    end
  end

  // Stage 2: error and the two gain products.
  err_t  err;
  prod_t pprod, iprod;
  prod_t s2_pprod_r, s2_iprod_r;
  data_t s2_upper_r;
  logic  s2_clr_r;

  assign err   = ERR_W'(s1_setpoint_r) - ERR_W'(s1_measured_r);
  assign pprod = PROD_W'(err) * PROD_W'(pgain_r);
  assign iprod = PROD_W'(err) * PROD_W'(igain_r);

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_pprod_r <= pprod;
      s2_iprod_r <= iprod;
      s2_upper_r <= s1_upper_r;
      s2_clr_r   <= s1_clr_r;
    end
  end

  // Stage 3: scaling, integrator step and output sum.
  prod_t pterm, iterm;

  pictl_scale u_pscale (
    .prod_i  (s2_pprod_r),
    .shift_i (pshift_r),
    .term_o  (pterm)
  );

  pictl_scale u_iscale (
    .prod_i  (s2_iprod_r),
    .shift_i (ishift_r),
    .term_o  (iterm)
  );

  acc_t  integ_r, integ_nxt;
  acc_t  high, low, acc, sum;
  data_t out_value_r;

  assign high = {s2_upper_r, {LIMIT_POS{1'b0}}};
  assign low  = {lower_r, {LIMIT_POS{1'b0}}};
  assign acc  = sat_clamp(wide_t'(integ_r) + wide_t'(iterm), high, low);
  assign sum  = sat_clamp(wide_t'(acc) + wide_t'(pterm), high, low);
  assign integ_nxt = s2_clr_r ? '0 : acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (s2_go) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_value_r <= sum[ACC_W-1:LIMIT_POS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_control_value = out_value_r;

`ifndef SYNTHESIS
  // A word with the clear flag leaves a zero integrator behind.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go && s2_clr_r |=> integ_r == '0)
    else $error("integrator not cleared");

  // The integrator only moves when a word enters the result register.
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_go |=> $stable(integ_r))
    else $error("integrator changed without a word");

  // The lower clamp is applied last, so a fresh result never sits below it.
  a_out_above_lower: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> $signed(out_control_value) >= $signed(lower_r))
    else $error("result below lower limit");

  // An accepted word always lands in the input register.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted word lost");
`endif

endmodule
`default_nettype wire
